// ===== hw/rtl/prs_pkg.sv =====
// shared constants, types and helpers of the pyramid rgb sampler
`timescale 1ns / 1ps
package prs_pkg;

   // parameter defaults
   localparam int unsigned DEF_MAX_COLS   = 256;
   localparam int unsigned DEF_MAX_ROWS   = 256;
   localparam int unsigned DEF_MAX_LEVELS = 4;
   localparam int unsigned DEF_FRAC_BITS  = 8;

   // fixed field widths
   localparam int unsigned DIM_W     = 9;
   localparam int unsigned SHIFT_W   = 3;
   localparam int unsigned LVLCNT_W  = 3;
   localparam int unsigned LEVEL_W   = 2;
   localparam int unsigned INDEX_W   = 16;
   localparam int unsigned PIX_W     = 16;
   localparam int unsigned RGB_W     = 3 * PIX_W;
   localparam int unsigned COORD_W   = 17;
   localparam int unsigned CSR_W     = 9;
   localparam int unsigned CSR_IDX_W = 2;

   // subsampling shift limits
   localparam logic [SHIFT_W-1:0] SHIFT_MIN = 3'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 3'd5;

   // register reset values
   localparam logic [DIM_W-1:0]    RST_BASE_COLS   = 9'd256;
   localparam logic [DIM_W-1:0]    RST_BASE_ROWS   = 9'd256;
   localparam logic [SHIFT_W-1:0]  RST_SUB_SHIFT   = 3'd1;
   localparam logic [LVLCNT_W-1:0] RST_LEVEL_COUNT = 3'd4;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_COLS   = 2'd0,
      CSR_BASE_ROWS   = 2'd1,
      CSR_SUB_SHIFT   = 2'd2,
      CSR_LEVEL_COUNT = 2'd3
   } csr_index_type;

   // control that travels with an item down the pipeline
   typedef struct packed {
      logic valid;
      logic query;
      logic bad;
      logic write;
   } prs_ctl_type;

   // first store entry of a level; levels are packed at factor two
   function automatic int unsigned level_base(input int unsigned mc, input int unsigned mr,
                                              input int unsigned lvl);
      int unsigned acc;
      acc = 0;
      for (int unsigned i = 0; i < 8; i++) begin
         if (i < lvl) begin
            acc = acc + (mc >> i) * (mr >> i);
         end
      end
      return acc;
   endfunction

endpackage

// ===== hw/rtl/prs_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module prs_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/prs_addr.sv =====
// level geometry, range check and store address generation
`timescale 1ns / 1ps
module prs_addr
   import prs_pkg::*;
#(
   parameter int unsigned MAX_COLS   = DEF_MAX_COLS,
   parameter int unsigned MAX_ROWS   = DEF_MAX_ROWS,
   parameter int unsigned MAX_LEVELS = DEF_MAX_LEVELS,
   parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS,
   parameter int unsigned AW         = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic                    in_kind,
   input  logic [LEVEL_W-1:0]      in_level,
   input  logic [INDEX_W-1:0]      in_index,
   input  logic [RGB_W-1:0]        in_rgb,
   input  logic [COORD_W-1:0]      in_x,
   input  logic [COORD_W-1:0]      in_y,
   input  logic [DIM_W-1:0]        cols_cap,
   input  logic [DIM_W-1:0]        rows_cap,
   input  logic [SHIFT_W-1:0]      shift_eff,
   input  logic [3:0]              levels_eff,
   output prs_ctl_type             ctl_out,
   output logic [AW-1:0]           wr_addr,
   output logic [RGB_W-1:0]        wr_data,
   output logic [AW-1:0]           rd_top,
   output logic [AW-1:0]           rd_bot,
   output logic [FRAC_BITS-1:0]    ax_out,
   output logic [FRAC_BITS-1:0]    ay_out
);

   localparam int unsigned XT_W = COORD_W - 1 - FRAC_BITS;

   // stage one: geometry and range check
   logic [4:0]           amt;
   logic [DIM_W-1:0]     cols_in, rows_in;
   logic                 used_in;
   logic [XT_W-1:0]      xt_in, yt_in;
   logic                 bad_in;
   logic [AW-1:0]        off_in;

   assign amt     = 5'(shift_eff) * 5'(in_level);
   assign cols_in = cols_cap >> amt;
   assign rows_in = rows_cap >> amt;
   assign used_in = 4'(in_level) < levels_eff;
   assign xt_in   = in_x[COORD_W-2:FRAC_BITS];
   assign yt_in   = in_y[COORD_W-2:FRAC_BITS];
   assign off_in  = AW'(level_base(MAX_COLS, MAX_ROWS, 32'(in_level)));
   assign bad_in  = !used_in || in_x[COORD_W-1] || in_y[COORD_W-1]
                    || (COORD_W'(xt_in) + COORD_W'(1) >= COORD_W'(cols_in))
                    || (COORD_W'(yt_in) + COORD_W'(1) >= COORD_W'(rows_in));

   prs_ctl_type          ctl1_ff;
   logic                 used1_ff;
   logic [DIM_W-1:0]     cols1_ff, rows1_ff;
   logic [AW-1:0]        off1_ff;
   logic [INDEX_W-1:0]   idx1_ff;
   logic [RGB_W-1:0]     rgb1_ff;
   logic [XT_W-1:0]      xt1_ff, yt1_ff;
   logic [FRAC_BITS-1:0] ax1_ff, ay1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (en) begin
         ctl1_ff.valid <= in_valid;
         ctl1_ff.query <= in_kind == KIND_QUERY;
         ctl1_ff.bad   <= bad_in;
         ctl1_ff.write <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         used1_ff <= used_in;
         cols1_ff <= cols_in;
         rows1_ff <= rows_in;
         off1_ff  <= off_in;
         idx1_ff  <= in_index;
         rgb1_ff  <= in_rgb;
         xt1_ff   <= xt_in;
         yt1_ff   <= yt_in;
         ax1_ff   <= in_x[FRAC_BITS-1:0];
         ay1_ff   <= in_y[FRAC_BITS-1:0];
      end
   end

   // stage two: row-major address of the top-left neighbor, load address
   logic [XT_W+DIM_W-1:0] row_prod;
   logic [2*DIM_W-1:0]    size;
   logic [AW-1:0]         top_in;
   logic                  write_in;
   prs_ctl_type           ctl2_in;

   assign row_prod = (XT_W+DIM_W)'(yt1_ff) * (XT_W+DIM_W)'(cols1_ff);
   assign size     = (2*DIM_W)'(cols1_ff) * (2*DIM_W)'(rows1_ff);
   assign top_in   = off1_ff + AW'(row_prod) + AW'(xt1_ff);
   assign write_in = ctl1_ff.valid && !ctl1_ff.query && used1_ff
                     && (32'(idx1_ff) < 32'(size));

   // control with the store write decision folded in
   always_comb begin
      ctl2_in       = ctl1_ff;
      ctl2_in.write = write_in;
   end

   prs_ctl_type          ctl2_ff;
   logic [AW-1:0]        wr_addr_ff, rd_top_ff, rd_bot_ff;
   logic [RGB_W-1:0]     wr_data_ff;
   logic [FRAC_BITS-1:0] ax2_ff, ay2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else if (en) begin
         ctl2_ff <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wr_addr_ff <= off1_ff + AW'(idx1_ff);
         wr_data_ff <= rgb1_ff;
         rd_top_ff  <= top_in;
         rd_bot_ff  <= top_in + AW'(cols1_ff);
         ax2_ff     <= ax1_ff;
         ay2_ff     <= ay1_ff;
      end
   end

   assign ctl_out = ctl2_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;
   assign rd_top  = rd_top_ff;
   assign rd_bot  = rd_bot_ff;
   assign ax_out  = ax2_ff;
   assign ay_out  = ay2_ff;

endmodule

// ===== hw/rtl/prs_store.sv =====
// pixel store: two copies, each split into even and odd banks
`timescale 1ns / 1ps
module prs_store
   import prs_pkg::*;
#(
   parameter int unsigned DEPTH = 87040,
   parameter int unsigned AW    = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [RGB_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_top,
   input  logic [AW-1:0]    rd_bot,
   output logic [RGB_W-1:0] pix00,
   output logic [RGB_W-1:0] pix01,
   output logic [RGB_W-1:0] pix10,
   output logic [RGB_W-1:0] pix11
);

   localparam int unsigned HD  = (DEPTH + 1) / 2;
   localparam int unsigned HAW = (HD > 1) ? $clog2(HD) : 1;

   logic [HAW-1:0]   wr_half;
   logic [AW:0]      top_inc, bot_inc;
   logic [RGB_W-1:0] top_even, top_odd, bot_even, bot_odd;
   logic             top_par_ff, bot_par_ff;

   assign wr_half = HAW'(wr_addr >> 1);
   assign top_inc = (AW+1)'(rd_top) + (AW+1)'(1);
   assign bot_inc = (AW+1)'(rd_bot) + (AW+1)'(1);

   // top row copy: pair at rd_top and rd_top+1
   prs_ram #(.WIDTH(RGB_W), .DEPTH(HD)) u_top_even (
      .clock(clock), .wr_en(wr_en && en && !wr_addr[0]), .wr_addr(wr_half),
      .wr_data(wr_data), .rd_en(en), .rd_addr(HAW'(top_inc >> 1)), .rd_data(top_even));
   prs_ram #(.WIDTH(RGB_W), .DEPTH(HD)) u_top_odd (
      .clock(clock), .wr_en(wr_en && en && wr_addr[0]), .wr_addr(wr_half),
      .wr_data(wr_data), .rd_en(en), .rd_addr(HAW'(rd_top >> 1)), .rd_data(top_odd));

   // bottom row copy: pair at rd_bot and rd_bot+1
   prs_ram #(.WIDTH(RGB_W), .DEPTH(HD)) u_bot_even (
      .clock(clock), .wr_en(wr_en && en && !wr_addr[0]), .wr_addr(wr_half),
      .wr_data(wr_data), .rd_en(en), .rd_addr(HAW'(bot_inc >> 1)), .rd_data(bot_even));
   prs_ram #(.WIDTH(RGB_W), .DEPTH(HD)) u_bot_odd (
      .clock(clock), .wr_en(wr_en && en && wr_addr[0]), .wr_addr(wr_half),
      .wr_data(wr_data), .rd_en(en), .rd_addr(HAW'(rd_bot >> 1)), .rd_data(bot_odd));

   // parity of the left neighbor steers the bank outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         top_par_ff <= 1'b0;
         bot_par_ff <= 1'b0;
      end else if (en) begin
         top_par_ff <= rd_top[0];
         bot_par_ff <= rd_bot[0];
      end
   end

   assign pix00 = top_par_ff ? top_odd  : top_even;
   assign pix01 = top_par_ff ? top_even : top_odd;
   assign pix10 = bot_par_ff ? bot_odd  : bot_even;
   assign pix11 = bot_par_ff ? bot_even : bot_odd;

endmodule

// ===== hw/rtl/prs_blend.sv =====
// bilinear blend of the four neighbors, three channels in parallel
`timescale 1ns / 1ps
module prs_blend
   import prs_pkg::*;
#(
   parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  prs_ctl_type          ctl_in,
   input  logic [FRAC_BITS-1:0] ax_in,
   input  logic [FRAC_BITS-1:0] ay_in,
   input  logic [RGB_W-1:0]     pix00,
   input  logic [RGB_W-1:0]     pix01,
   input  logic [RGB_W-1:0]     pix10,
   input  logic [RGB_W-1:0]     pix11,
   output prs_ctl_type          ctl_out,
   output logic [RGB_W-1:0]     rgb_out
);

   localparam int unsigned WW  = FRAC_BITS + 1;
   localparam int unsigned P1W = PIX_W + WW;
   localparam int unsigned SW  = P1W + 1;
   localparam int unsigned MW  = SW + WW;
   localparam int unsigned TW  = MW + 1;
   localparam logic [WW-1:0] ONE  = WW'(1) << FRAC_BITS;
   localparam logic [TW-1:0] HALF = TW'(1) << (2 * FRAC_BITS - 1);

   // stage three: wait for the store read
   prs_ctl_type          ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;
   logic [FRAC_BITS-1:0] ax3_ff, ay3_ff, ay4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (en) begin
         ctl3_ff <= ctl_in;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax3_ff <= ax_in;
         ay3_ff <= ay_in;
         ay4_ff <= ay3_ff;
      end
   end

   logic [WW-1:0] wx0, wx1, wy0, wy1;
   assign wx0 = ONE - WW'(ax3_ff);
   assign wx1 = WW'(ax3_ff);
   assign wy0 = ONE - WW'(ay4_ff);
   assign wy1 = WW'(ay4_ff);

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [PIX_W-1:0] a, b, d, e;
      logic [P1W-1:0]   t0_ff, t1_ff, b0_ff, b1_ff;
      logic [SW-1:0]    top_sum, bot_sum;
      logic [MW-1:0]    mt_ff, mb_ff;
      logic [TW-1:0]    total;
      logic [PIX_W-1:0] res_ff;

      assign a = pix00[c*PIX_W +: PIX_W];
      assign b = pix01[c*PIX_W +: PIX_W];
      assign d = pix10[c*PIX_W +: PIX_W];
      assign e = pix11[c*PIX_W +: PIX_W];

      // stage four: horizontal weights
      always_ff @(posedge clock) begin
         if (en) begin
            t0_ff <= P1W'(a) * P1W'(wx0);
            t1_ff <= P1W'(b) * P1W'(wx1);
            b0_ff <= P1W'(d) * P1W'(wx0);
            b1_ff <= P1W'(e) * P1W'(wx1);
         end
      end

      // stage five: row sums and vertical weights
      assign top_sum = SW'(t0_ff) + SW'(t1_ff);
      assign bot_sum = SW'(b0_ff) + SW'(b1_ff);

      always_ff @(posedge clock) begin
         if (en) begin
            mt_ff <= MW'(top_sum) * MW'(wy0);
            mb_ff <= MW'(bot_sum) * MW'(wy1);
         end
      end

      // stage six: round half up, drop fraction, zero when out of range
      assign total = TW'(mt_ff) + TW'(mb_ff) + HALF;

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff <= ctl5_ff.bad ? '0 : total[2*FRAC_BITS +: PIX_W];
         end
      end

      assign rgb_out[c*PIX_W +: PIX_W] = res_ff;
   end

   assign ctl_out = ctl6_ff;

endmodule

// ===== hw/rtl/pyramid_rgb_bilinear_sampler_unit.sv =====
// top level of the pyramid rgb bilinear sampler
`timescale 1ns / 1ps
// Holds an RGB image pyramid and answers bilinear samples. A load item
// (kind 0) writes one Q8.8 RGB pixel at a level and row-major index and gives
// no result; a query item (kind 1) gives the blend of the four neighbors of
// a signed fixed-point coordinate, or status 1 with zero color when the
// coordinate is off the level. One item is taken every clock cycle while no
// result is stalled. The rate is set by the pixel store, held as two copies
// split into even and odd banks, so the four neighbors come out of a single
// read while a load writes all copies. A stalled result stalls the whole
// pipeline. Pixels read before being loaded give undefined values. The user
// must write registers only while the unit is idle; the unit itself does
// not enforce this.
module pyramid_rgb_bilinear_sampler_unit
   import prs_pkg::*;
#(
   parameter int unsigned MAX_COLS   = DEF_MAX_COLS,
   parameter int unsigned MAX_ROWS   = DEF_MAX_ROWS,
   parameter int unsigned MAX_LEVELS = DEF_MAX_LEVELS,
   parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [LEVEL_W-1:0]   req_level,
   input  logic [INDEX_W-1:0]   req_pixel_index,
   input  logic [PIX_W-1:0]     req_red_in,
   input  logic [PIX_W-1:0]     req_green_in,
   input  logic [PIX_W-1:0]     req_blue_in,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_red_out,
   output logic [PIX_W-1:0]     rsp_green_out,
   output logic [PIX_W-1:0]     rsp_blue_out,
   output logic                 rsp_status,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int unsigned DEPTH = level_base(MAX_COLS, MAX_ROWS, MAX_LEVELS);
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [DIM_W-1:0]    base_cols_ff, base_rows_ff;
   logic [SHIFT_W-1:0]  sub_shift_ff;
   logic [LVLCNT_W-1:0] level_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_cols_ff   <= RST_BASE_COLS;
         base_rows_ff   <= RST_BASE_ROWS;
         sub_shift_ff   <= RST_SUB_SHIFT;
         level_count_ff <= RST_LEVEL_COUNT;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_COLS:   base_cols_ff   <= csr_data;
            CSR_BASE_ROWS:   base_rows_ff   <= csr_data;
            CSR_SUB_SHIFT:   sub_shift_ff   <= csr_data[SHIFT_W-1:0];
            CSR_LEVEL_COUNT: level_count_ff <= csr_data[LVLCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // saturated register values
   logic [DIM_W-1:0]   cols_cap, rows_cap;
   logic [SHIFT_W-1:0] shift_eff;
   logic [3:0]         levels_eff;

   assign cols_cap = (32'(base_cols_ff) > MAX_COLS) ? DIM_W'(MAX_COLS) : base_cols_ff;
   assign rows_cap = (32'(base_rows_ff) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : base_rows_ff;

   always_comb begin
      priority if (sub_shift_ff < SHIFT_MIN) shift_eff = SHIFT_MIN;
      else if (sub_shift_ff > SHIFT_MAX)     shift_eff = SHIFT_MAX;
      else                                   shift_eff = sub_shift_ff;
   end

   always_comb begin
      priority if (level_count_ff == '0)          levels_eff = 4'd1;
      else if (32'(level_count_ff) > MAX_LEVELS) levels_eff = 4'(MAX_LEVELS);
      else                                        levels_eff = 4'(level_count_ff);
   end

   // whole pipeline advances unless a result is held
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   prs_ctl_type          ctl_addr, ctl_blend;
   logic [AW-1:0]        wr_addr, rd_top, rd_bot;
   logic [RGB_W-1:0]     wr_data, pix00, pix01, pix10, pix11, rgb;
   logic [FRAC_BITS-1:0] ax, ay;

   prs_addr #(
      .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_LEVELS(MAX_LEVELS),
      .FRAC_BITS(FRAC_BITS), .AW(AW)
   ) u_addr (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_kind(req_kind), .in_level(req_level),
      .in_index(req_pixel_index),
      .in_rgb({req_blue_in, req_green_in, req_red_in}),
      .in_x(req_x_coord), .in_y(req_y_coord),
      .cols_cap(cols_cap), .rows_cap(rows_cap),
      .shift_eff(shift_eff), .levels_eff(levels_eff),
      .ctl_out(ctl_addr), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_top(rd_top), .rd_bot(rd_bot), .ax_out(ax), .ay_out(ay)
   );

   prs_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock(clock), .reset(reset), .en(en),
      .wr_en(ctl_addr.write), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_top(rd_top), .rd_bot(rd_bot),
      .pix00(pix00), .pix01(pix01), .pix10(pix10), .pix11(pix11)
   );

   prs_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock(clock), .reset(reset), .en(en),
      .ctl_in(ctl_addr), .ax_in(ax), .ay_in(ay),
      .pix00(pix00), .pix01(pix01), .pix10(pix10), .pix11(pix11),
      .ctl_out(ctl_blend), .rgb_out(rgb)
   );

   // only queries give a result
   assign rsp_valid     = ctl_blend.valid && ctl_blend.query;
   assign rsp_status    = ctl_blend.bad;
   assign rsp_red_out   = rgb[0 +: PIX_W];
   assign rsp_green_out = rgb[PIX_W +: PIX_W];
   assign rsp_blue_out  = rgb[2*PIX_W +: PIX_W];

endmodule

// ===== sim/pyramid_rgb_bilinear_sampler_unit_tb.sv =====
// testbench for the pyramid rgb bilinear sampler: directed and random items, self-checking
`timescale 1ns / 1ps
module pyramid_rgb_bilinear_sampler_unit_tb
   import prs_pkg::*;
();

   localparam int unsigned STORE_DEPTH = (256 * 256 * 4) / 3 + 4;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic                      kind;
      logic [LEVEL_W-1:0]        level;
      logic [INDEX_W-1:0]        index;
      logic [PIX_W-1:0]          red;
      logic [PIX_W-1:0]          green;
      logic [PIX_W-1:0]          blue;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } sample_item_type;

   typedef struct {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             status;
   } sample_result_type;

   // pyramid store model and queue of awaited samples
   class pyramid_scoreboard;
      int unsigned          cols_reg, rows_reg, shift_reg, levels_reg;
      logic [RGB_W-1:0]     pixels[int unsigned];
      sample_result_type    awaited[$];
      int unsigned          errors;

      function new();
         cols_reg   = RST_BASE_COLS;
         rows_reg   = RST_BASE_ROWS;
         shift_reg  = RST_SUB_SHIFT;
         levels_reg = RST_LEVEL_COUNT;
         errors     = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_BASE_COLS:   cols_reg = v;
            CSR_BASE_ROWS:   rows_reg = v;
            CSR_SUB_SHIFT:   shift_reg = v[SHIFT_W-1:0];
            CSR_LEVEL_COUNT: levels_reg = v[LVLCNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned levels_used();
         if (levels_reg < 1) return 1;
         if (levels_reg > 4) return 4;
         return levels_reg;
      endfunction

      function int unsigned dim(int unsigned base, int unsigned lvl);
         int unsigned s;
         s = (shift_reg < 1) ? 1 : (shift_reg > 5) ? 5 : shift_reg;
         if (base > 256) base = 256;
         return base >> (s * lvl);
      endfunction

      function int unsigned cols_at(int unsigned lvl);
         return (lvl < levels_used()) ? dim(cols_reg, lvl) : 0;
      endfunction

      function int unsigned rows_at(int unsigned lvl);
         return (lvl < levels_used()) ? dim(rows_reg, lvl) : 0;
      endfunction

      function int unsigned offset(int unsigned lvl);
         int unsigned acc;
         acc = 0;
         for (int unsigned i = 0; i < lvl; i++) acc += (256 >> i) * (256 >> i);
         return acc;
      endfunction

      // top-left neighbor address; returns 1 when the coordinate is off the level or past the store end
      function bit locate(int unsigned lvl, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          output int unsigned p, output int unsigned c);
         int unsigned r, xt, yt;
         c = cols_at(lvl);
         r = rows_at(lvl);
         p = 0;
         xt = x[15:8];
         yt = y[15:8];
         if (lvl >= levels_used() || x[16] || y[16] || c < 2 || r < 2) return 1;
         if (xt > c - 2 || yt > r - 2) return 1;
         p = offset(lvl) + yt * c + xt;
         return (p + c + 1 >= STORE_DEPTH);
      endfunction

      function logic [PIX_W-1:0] blend(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                       logic [PIX_W-1:0] c, logic [PIX_W-1:0] d,
                                       longint unsigned ax, longint unsigned ay);
         longint unsigned acc;
         acc = a * (256 - ax) * (256 - ay) + b * ax * (256 - ay) + c * (256 - ax) * ay
             + d * ax * ay + 64'd32768;
         return acc[31:16];
      endfunction

      function logic [RGB_W-1:0] peek(int unsigned a);
         return pixels.exists(a) ? pixels[a] : '0;
      endfunction

      function void note(sample_item_type it);
         int unsigned p, c;
         logic [RGB_W-1:0] n00, n01, n10, n11;
         sample_result_type res;
         if (it.kind == KIND_LOAD) begin
            if (it.level < levels_used() && it.index < cols_at(it.level) * rows_at(it.level))
               pixels[offset(it.level) + it.index] = {it.red, it.green, it.blue};
            return;
         end
         if (locate(it.level, it.x, it.y, p, c)) begin
            res = '{16'd0, 16'd0, 16'd0, 1'b1};
         end else begin
            n00 = peek(p); n01 = peek(p + 1); n10 = peek(p + c); n11 = peek(p + c + 1);
            res.red   = blend(n00[47:32], n01[47:32], n10[47:32], n11[47:32],
                              it.x[7:0], it.y[7:0]);
            res.green = blend(n00[31:16], n01[31:16], n10[31:16], n11[31:16],
                              it.x[7:0], it.y[7:0]);
            res.blue  = blend(n00[15:0], n01[15:0], n10[15:0], n11[15:0],
                              it.x[7:0], it.y[7:0]);
            res.status = 1'b0;
         end
         awaited.push_back(res);
      endfunction

      function void check(sample_result_type got);
         sample_result_type exp;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected sample result %p", got);
            return;
         end
         exp = awaited.pop_front();
         if (got.red !== exp.red || got.green !== exp.green || got.blue !== exp.blue
             || got.status !== exp.status) begin
            errors++;
            if (errors <= 10) $display("sample mismatch: expected %p, got %p", exp, got);
         end
      endfunction
   endclass

   logic                      clock, reset;
   logic                      req_valid, req_stall, req_kind;
   logic [LEVEL_W-1:0]        req_level;
   logic [INDEX_W-1:0]        req_pixel_index;
   logic [PIX_W-1:0]          req_red_in, req_green_in, req_blue_in;
   logic signed [COORD_W-1:0] req_x_coord, req_y_coord;
   logic                      rsp_valid, rsp_stall, rsp_status;
   logic [PIX_W-1:0]          rsp_red_out, rsp_green_out, rsp_blue_out;
   logic                      csr_write;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_W-1:0]          csr_data;

   pyramid_scoreboard sb;
   int unsigned send_idle_pct, recv_stall_pct, hold_cycles, quiet_cycles;

   pyramid_rgb_bilinear_sampler_unit u_dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stall pattern, with an occasional long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // result checking and watchdog
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check('{rsp_red_out, rsp_green_out, rsp_blue_out, rsp_status});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL pyramid_rgb_bilinear_sampler_unit");
            $finish;
         end
      end
   end

   // offer one item, wait for its acceptance
   task automatic push_item(sample_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_kind = it.kind;
      req_level = it.level;
      req_pixel_index = it.index;
      req_red_in = it.red;
      req_green_in = it.green;
      req_blue_in = it.blue;
      req_x_coord = it.x;
      req_y_coord = it.y;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note(it);
      @(negedge clock);
   endtask

   task automatic load_pixel(int unsigned lvl, int unsigned idx,
                             logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      push_item('{KIND_LOAD, LEVEL_W'(lvl), INDEX_W'(idx), r, g, b,
                  COORD_W'($urandom), COORD_W'($urandom)});
   endtask

   // query, first loading any neighbor not yet written
   task automatic sample_at(int unsigned lvl, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int unsigned p, c, a, base;
      if (!sb.locate(lvl, x, y, p, c)) begin
         base = sb.offset(lvl);
         for (int k = 0; k < 4; k++) begin
            a = p + ((k & 1) ? 1 : 0) + ((k & 2) ? c : 0);
            if (!sb.pixels.exists(a))
               load_pixel(lvl, a - base, PIX_W'($urandom), PIX_W'($urandom),
                          PIX_W'($urandom));
         end
      end
      push_item('{KIND_QUERY, LEVEL_W'(lvl), INDEX_W'($urandom), PIX_W'($urandom),
                  PIX_W'($urandom), PIX_W'($urandom), x, y});
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_regs(int unsigned cols, int unsigned rows,
                             int unsigned shift, int unsigned levels);
      logic [CSR_W-1:0] vals[4];
      vals = '{CSR_W'(cols), CSR_W'(rows), CSR_W'(shift), CSR_W'(levels)};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_write = 1'b1;
         csr_index = csr_index_type'(i);
         csr_data = vals[i];
         sb.set_reg(csr_index_type'(i), vals[i]);
         @(negedge clock);
      end
      csr_write = 1'b0;
   endtask

   task automatic random_coord(int unsigned span, output logic [COORD_W-1:0] v);
      if (span >= 2 && $urandom_range(0, 99) < 85)
         v = {1'b0, 8'($urandom_range(0, span - 2)), 8'($urandom)};
      else
         v = COORD_W'($urandom);
   endtask

   // random mix: mostly in-range queries and loads, some noise
   task automatic random_phase(int unsigned n, bit pressure);
      int unsigned lvl, c, r, pick;
      logic [COORD_W-1:0] x, y;
      sample_item_type it;
      for (int unsigned i = 0; i < n; i++) begin
         if (pressure && i == n / 3) hold_cycles = 300;
         if (pressure && i == 2 * n / 3) wait_idle();
         lvl = $urandom_range(0, 3);
         c = sb.cols_at(lvl);
         r = sb.rows_at(lvl);
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            random_coord(c, x);
            random_coord(r, y);
            sample_at(lvl, x, y);
         end else if (pick < 90 && c * r > 0) begin
            load_pixel(lvl, $urandom_range(0, c * r - 1), PIX_W'($urandom),
                       PIX_W'($urandom), PIX_W'($urandom));
         end else begin
            it = '{1'($urandom), LEVEL_W'($urandom), INDEX_W'($urandom), PIX_W'($urandom),
                   PIX_W'($urandom), PIX_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom)};
            if (it.kind == KIND_QUERY) sample_at(it.level, it.x, it.y);
            else push_item(it);
         end
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD;
      req_level = '0;
      req_pixel_index = '0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_x_coord = '0;
      req_y_coord = '0;
      csr_write = 1'b0;
      csr_index = CSR_BASE_COLS;
      csr_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: pixel extremes, fractions, rounding, edges, ignored loads
      load_pixel(0, 0, 16'hFFFF, 16'h0000, 16'hFFFF);
      load_pixel(0, 1, 16'hFFFF, 16'hFFFF, 16'h0000);
      load_pixel(0, 256, 16'h0000, 16'hFFFF, 16'hFFFF);
      load_pixel(0, 257, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      sample_at(0, 17'h00000, 17'h00000);
      sample_at(0, 17'h000FF, 17'h000FF);
      sample_at(0, 17'h00080, 17'h00080);
      sample_at(0, 17'h00040, 17'h000C0);
      sample_at(0, 17'h0FEFF, 17'h0FEFF);
      sample_at(0, 17'h0FF00, 17'h00000);
      sample_at(0, 17'h00000, 17'h0FF00);
      sample_at(0, 17'h1FF00, 17'h00000);
      sample_at(0, 17'h00000, 17'h10000);
      sample_at(0, 17'h0FFFF, 17'h0FFFF);
      load_pixel(0, 65535, 16'h1234, 16'h5678, 16'h9ABC);
      load_pixel(3, 1024, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      load_pixel(3, 65535, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      sample_at(3, 17'h01E80, 17'h01E80);
      sample_at(3, 17'h01F00, 17'h00000);
      write_regs(16, 16, 1, 2);
      load_pixel(2, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      sample_at(2, 17'h00000, 17'h00000);
      sample_at(1, 17'h00680, 17'h00680);

      // random phases across register settings, saturation included
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_regs(256, 256, 1, 4);
            1: write_regs(2, 2, 1, 1);
            2: write_regs(511, 0, 7, 0);
            3: write_regs(16, 9, 2, 3);
            4: write_regs(300, 300, 5, 7);
            5: write_regs(3, 2, 0, 2);
            6: write_regs(255, 100, 6, 5);
            default: write_regs(64, 64, 1, 4);
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         random_phase(120, ph == 0 || ph == 4);
      end

      send_idle_pct = 0;
      wait_idle();
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("PASS pyramid_rgb_bilinear_sampler_unit");
      end else begin
         $display("FAIL pyramid_rgb_bilinear_sampler_unit");
      end
      $finish;
   end

endmodule
